// ===== sv/hosts_record_parser_core_defines.svh =====
// Assertion macros for the hosts record parser.
// Checks run on the rising edge of clk; HRP_ASSERT is masked while rst_n is low.
`ifndef HOSTS_RECORD_PARSER_CORE_DEFINES_SVH
`define HOSTS_RECORD_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRP_ASSERT(lbl, prop, msg)
`define HRP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== sv/hrp_pkg.sv =====
package hrp_pkg;

  // Characters of interest
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Octet limits
  localparam logic [8:0] OCTET_SAT   = 9'd256;
  localparam logic [8:0] OCTET_MAX   = 9'd255;
  localparam logic [1:0] LAST_OCTET  = 2'd3;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // Result item kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [1:0] ST_OKAY    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EOT     = 2'd2;

  // One result item
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  name_char;
    logic        label_start;
    logic [31:0] address;
    logic [1:0]  status;
    logic [7:0]  name_length;
    logic        last;
  } res_t;

  // Results caused by one accepted input item (n of them, r0 first)
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

// ===== sv/hrp_in_if.sv =====
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== sv/hrp_out_if.sv =====
interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  name_char;
  logic        label_start;
  logic [31:0] address;
  logic [1:0]  status;
  logic [7:0]  name_length;
  logic        last;

  modport source (output valid, output item_kind, output name_char, output label_start,
                  output address, output status, output name_length, output last,
                  input ready);
  modport sink   (input valid, input item_kind, input name_char, input label_start,
                  input address, input status, input name_length, input last,
                  output ready);
endinterface

// ===== sv/hrp_parse.sv =====
// Per-byte parser: line state registers and the results one byte causes.
module hrp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output hrp_pkg::step_t     step
);

  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_ADDR = 4'b0010,
    PH_NAME = 4'b0100,
    PH_DROP = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  octet_index;
    logic [8:0]  octet_value;
    logic        octet_has_digit;
    logic [31:0] addr_acc;
    logic        label_has_char;
    logic        after_dot;
    logic [7:0]  name_count;
    logic        record_bad;
  } pst_t;

  localparam pst_t PST_CLEAR = '{phase: PH_SKIP, default: '0};

  pst_t st_r, st_nxt;

  // Summary of the open line
  function automatic hrp_pkg::res_t close_sum(input pst_t s);
    hrp_pkg::res_t r;
    r = '0;
    r.item_kind = hrp_pkg::KIND_SUMMARY;
    if (s.phase == PH_NAME && !s.record_bad && !s.after_dot) begin
      r.address     = s.addr_acc;
      r.status      = hrp_pkg::ST_OKAY;
      r.name_length = s.name_count;
    end else begin
      r.status = hrp_pkg::ST_INVALID;
    end
    return r;
  endfunction

  // Next state and results of the current byte
  always_comb begin
    pst_t          s;
    logic          brk;
    logic [11:0]   v;
    logic          has_a, has_b, has_c;
    hrp_pkg::res_t res_a, res_b, res_c;
    s     = st_r;
    brk   = (text_byte == hrp_pkg::CH_LF) || (text_byte == hrp_pkg::CH_CR);
    v     = 12'(st_r.octet_value) * 12'd10 + 12'(4'(text_byte - hrp_pkg::CH_ZERO));
    has_a = 1'b0;
    has_b = 1'b0;
    has_c = 1'b0;
    res_a = '0;
    res_b = '0;
    res_c = '0;
    res_c.item_kind = hrp_pkg::KIND_SUMMARY;
    res_c.status    = hrp_pkg::ST_EOT;

    if (s.phase == PH_SKIP && !brk) begin
      s.phase = PH_ADDR;
    end

    case (s.phase)
      PH_ADDR: begin
        if (brk) begin
          has_a = 1'b1;
          res_a = close_sum(s);
          s     = PST_CLEAR;
        end else if (text_byte inside {[hrp_pkg::CH_ZERO:hrp_pkg::CH_NINE]}) begin
          s.octet_value     = (v > 12'(hrp_pkg::OCTET_SAT)) ? hrp_pkg::OCTET_SAT : v[8:0];
          s.octet_has_digit = 1'b1;
        end else if (text_byte == hrp_pkg::CH_DOT || text_byte == hrp_pkg::CH_SPACE) begin
          if (!s.octet_has_digit || s.octet_value > hrp_pkg::OCTET_MAX) begin
            s.record_bad = 1'b1;
            s.phase      = PH_DROP;
          end else if (text_byte == hrp_pkg::CH_DOT) begin
            if (s.octet_index == hrp_pkg::LAST_OCTET) begin
              s.record_bad = 1'b1;
              s.phase      = PH_DROP;
            end else begin
              s.addr_acc        = {s.addr_acc[23:0], s.octet_value[7:0]};
              s.octet_index     = s.octet_index + 2'd1;
              s.octet_value     = '0;
              s.octet_has_digit = 1'b0;
            end
          end else if (s.octet_index != hrp_pkg::LAST_OCTET) begin
            s.record_bad = 1'b1;
            s.phase      = PH_DROP;
          end else begin
            s.addr_acc       = {s.addr_acc[23:0], s.octet_value[7:0]};
            s.phase          = PH_NAME;
            s.label_has_char = 1'b0;
            s.after_dot      = 1'b0;
            s.name_count     = '0;
          end
        end else begin
          s.record_bad = 1'b1;
          s.phase      = PH_DROP;
        end
      end
      PH_NAME: begin
        if (brk) begin
          has_a = 1'b1;
          res_a = close_sum(s);
          s     = PST_CLEAR;
        end else begin
          if (s.name_count != hrp_pkg::COUNT_MAX) begin
            s.name_count = s.name_count + 8'd1;
          end
          if (text_byte == hrp_pkg::CH_DOT) begin
            if (!s.label_has_char) begin
              s.record_bad = 1'b1;
              s.phase      = PH_DROP;
            end else begin
              s.label_has_char = 1'b0;
              s.after_dot      = 1'b1;
            end
          end else begin
            has_a             = 1'b1;
            res_a.item_kind   = hrp_pkg::KIND_CHAR;
            res_a.name_char   = (text_byte inside {[hrp_pkg::CH_UPPER_A:hrp_pkg::CH_UPPER_Z]})
                                ? text_byte + hrp_pkg::CASE_OFFSET : text_byte;
            res_a.label_start = !s.label_has_char;
            s.label_has_char  = 1'b1;
            s.after_dot       = 1'b0;
          end
        end
      end
      PH_DROP: begin
        if (brk) begin
          has_a = 1'b1;
          res_a = close_sum(s);
          s     = PST_CLEAR;
        end
      end
      default: ;
    endcase

    // End of text closes an open line, then EOF if there is room
    if (end_of_text) begin
      if (s.phase != PH_SKIP) begin
        has_b = 1'b1;
        res_b = close_sum(s);
      end
      has_c = !(has_a && has_b);
      s     = PST_CLEAR;
    end

    // Pack up to two results in order
    step.r0 = has_a ? res_a : (has_b ? res_b : res_c);
    step.r1 = has_a ? (has_b ? res_b : res_c) : res_c;
    step.n  = 2'(has_a) + 2'(has_b) + 2'(has_c);
    if (step.n == 2'd1) begin
      step.r0.last = 1'b1;
    end else if (step.n == 2'd2) begin
      step.r1.last = 1'b1;
    end

    st_nxt = accept ? s : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sv/hosts_record_parser_core.sv =====
// Channel   | Direction | Carries
// ----------+-----------+----------------------------------------------------
// in_chan   | sink      | text_byte, end_of_text: one text byte per item
// out_chan  | source    | item_kind, name_char, label_start, address, status,
//           |           | name_length, last: name characters and summaries
//
// A byte is parsed in the cycle it is accepted; its results appear in the next cycle.
// One byte per cycle while each byte gives at most one result and out_chan is ready;
// a byte giving two results (a line summary plus EOF, or last name character plus
// summary) stalls in_chan while the single output pair drains one item per cycle.
// Synchronous active-low reset empties the output pair and clears the line state.
// in_chan.ready follows out_chan.ready when one result is left to drain.
`include "hosts_record_parser_core_defines.svh"

module hosts_record_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  hrp_in_if.sink      in_chan,
  hrp_out_if.source   out_chan
);

  hrp_pkg::step_t step;
  hrp_pkg::res_t  res0_r, res0_nxt;
  hrp_pkg::res_t  res1_r, res1_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           in_fire;
  logic           out_fire;

  // Accept when the result pair is empty or its last item leaves this cycle
  assign in_chan.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_chan.valid && out_chan.ready;

  hrp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .text_byte   (in_chan.text_byte),
    .end_of_text (in_chan.end_of_text),
    .step        (step)
  );

  // Result pair: load on accept, shift on drain
  always_comb begin
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    cnt_nxt  = cnt_r;
    if (in_fire) begin
      res0_nxt = step.r0;
      res1_nxt = step.r1;
      cnt_nxt  = step.n;
    end else if (out_fire) begin
      res0_nxt = res1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  // Output side
  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.item_kind   = res0_r.item_kind;
  assign out_chan.name_char   = res0_r.name_char;
  assign out_chan.label_start = res0_r.label_start;
  assign out_chan.address     = res0_r.address;
  assign out_chan.status      = res0_r.status;
  assign out_chan.name_length = res0_r.name_length;
  assign out_chan.last        = res0_r.last;

  // Checks
  `HRP_ASSERT(a_cnt_range, cnt_r != 2'd3, "result count out of range")
  `HRP_ASSERT(a_last_order,
              (cnt_r == 2'd2) |-> (!res0_r.last && res1_r.last),
              "last mark misplaced in pair")
  `HRP_ASSERT(a_single_last, (cnt_r == 2'd1) |-> res0_r.last, "lone result without last mark")
  `HRP_ASSERT(a_eot_summary,
              (out_chan.valid && out_chan.status == hrp_pkg::ST_EOT) |->
                (out_chan.item_kind == hrp_pkg::KIND_SUMMARY && out_chan.last),
              "EOF item malformed")
  `HRP_ASSERT_RST(a_reset_empty, !rst_n |=> (cnt_r == 2'd0), "output not empty after reset")

endmodule
